// File: rtl/core/c8x_pkg.sv
package c8x_pkg;

    // fixed memory geometry
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = 12;
    localparam int VREG_NUM  = 16;
    localparam int VREG_AW   = 4;

    localparam logic [11:0] PC_START = 12'h200;
    localparam logic [15:0] OP_CLS   = 16'h00E0;
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [3:0]  VF_IDX   = 4'hF;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEI  = 4'h3;
    localparam logic [3:0] GRP_SNEI = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_LDX  = 4'hA;
    localparam logic [3:0] GRP_JPV  = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;

    // 8XYn sub-operations
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // controller to datapath commands
    typedef struct packed {
        logic clr;      // reset sweep step
        logic accept;   // capture item
        logic load_wr;  // mode 0 memory write
        logic fb_cap;   // capture framebuffer read
        logic fetch_hi;
        logic fetch_lo;
        logic rd_x;
        logic rd_y;
        logic exec;
        logic wr_flag;
        logic mod_step;
        logic row_mem;
        logic row_b0;
        logic row_w0;
        logic row_w1;
        logic cls_step;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic cls_last;
        logic is_cls;
        logic is_drw;
        logic flag_op;
        logic mod_done;
        logic row_end;
        logic has_b1;
    } stat_t;

endpackage

// File: rtl/core/chip8_instruction_execute_unit.sv
// Channel  | Handshake         | Beat
// ---------+-------------------+------------------------------------------
// input    | start & !busy     | mode, addr, data, rand_byte
// result   | done (one cycle)  | prog_counter, index_value, flag_value,
//          |                   | read_byte, executed_opcode, unimplemented
//
// After reset a clearing pass zeroes program memory, V registers, stack and
// framebuffer with busy high.
// Load and mode three go straight to the result, a framebuffer read adds a
// capture step, and an instruction makes two program memory reads and two V
// register reads on one port. DRW adds modulo steps and then, per row, a
// program memory read and a read-modify-write of one or two framebuffer
// bytes; CLS adds one clearing step per framebuffer byte.
// The receiver cannot stall; the result beat is shown for one cycle only.
module chip8_instruction_execute_unit
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int SCREEN_W    = 64,
    parameter int SCREEN_H    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [11:0] addr,
    input  logic [7:0]  data,
    input  logic [7:0]  rand_byte,
    output logic        done,
    output logic [11:0] prog_counter,
    output logic [11:0] index_value,
    output logic [7:0]  flag_value,
    output logic [7:0]  read_byte,
    output logic [15:0] executed_opcode,
    output logic        unimplemented
);

    cmd_t  cmd;
    stat_t stat;

    c8x_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .stat(stat), .cmd(cmd), .busy(busy), .done(done)
    );

    c8x_dpath #(
        .STACK_DEPTH(STACK_DEPTH), .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .addr(addr), .data(data), .rand_byte(rand_byte),
        .prog_counter(prog_counter), .index_value(index_value),
        .flag_value(flag_value), .read_byte(read_byte),
        .executed_opcode(executed_opcode), .unimplemented(unimplemented)
    );

endmodule

// File: rtl/core/c8x_ram.sv
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/c8x_ctrl.sv
module c8x_ctrl
    import c8x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [16:0] {
        ST_CLEAR  = 17'h00001,
        ST_IDLE   = 17'h00002,
        ST_FBRD   = 17'h00004,
        ST_FETCH1 = 17'h00008,
        ST_FETCH2 = 17'h00010,
        ST_RDX    = 17'h00020,
        ST_RDY    = 17'h00040,
        ST_EXEC   = 17'h00080,
        ST_WRF    = 17'h00100,
        ST_MOD    = 17'h00200,
        ST_ROWM   = 17'h00400,
        ST_ROWB0  = 17'h00800,
        ST_ROWW0  = 17'h01000,
        ST_ROWW1  = 17'h02000,
        ST_CLS    = 17'h04000,
        ST_DONE   = 17'h08000,
        ST_SPARE  = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    case (mode)
                        MODE_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                            state_next  = ST_DONE;
                        end
                        MODE_EXEC: state_next = ST_FETCH1;
                        MODE_READ: state_next = ST_FBRD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_FBRD:
            begin
                cmd.fb_cap = 1'b1;
                state_next = ST_DONE;
            end
            ST_FETCH1:
            begin
                cmd.fetch_hi = 1'b1;
                state_next   = ST_FETCH2;
            end
            ST_FETCH2:
            begin
                cmd.fetch_lo = 1'b1;
                state_next   = ST_RDX;
            end
            ST_RDX:
            begin
                cmd.rd_x   = 1'b1;
                state_next = ST_RDY;
            end
            ST_RDY:
            begin
                cmd.rd_y   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_drw)
                begin
                    state_next = ST_MOD;
                end
                else if (stat.is_cls)
                begin
                    state_next = ST_CLS;
                end
                else if (stat.flag_op)
                begin
                    state_next = ST_WRF;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRF:
            begin
                cmd.wr_flag = 1'b1;
                state_next  = ST_DONE;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = ST_ROWM;
                end
            end
            ST_ROWM:
            begin
                if (stat.row_end)
                begin
                    state_next = ST_WRF;
                end
                else
                begin
                    cmd.row_mem = 1'b1;
                    state_next  = ST_ROWB0;
                end
            end
            ST_ROWB0:
            begin
                cmd.row_b0 = 1'b1;
                state_next = ST_ROWW0;
            end
            ST_ROWW0:
            begin
                cmd.row_w0 = 1'b1;
                state_next = stat.has_b1 ? ST_ROWW1 : ST_ROWM;
            end
            ST_ROWW1:
            begin
                cmd.row_w1 = 1'b1;
                state_next = ST_ROWM;
            end
            ST_CLS:
            begin
                cmd.cls_step = 1'b1;
                if (stat.cls_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            ST_SPARE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// File: rtl/core/c8x_dpath.sv
module c8x_dpath
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int SCREEN_W    = 64,
    parameter int SCREEN_H    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [11:0] addr,
    input  logic [7:0]  data,
    input  logic [7:0]  rand_byte,
    output logic [11:0] prog_counter,
    output logic [11:0] index_value,
    output logic [7:0]  flag_value,
    output logic [7:0]  read_byte,
    output logic [15:0] executed_opcode,
    output logic        unimplemented
);

    localparam int ROW_BYTES = (SCREEN_W + 7) / 8;
    localparam int FB_BYTES  = ROW_BYTES * SCREEN_H;
    localparam int FB_AW     = $clog2(FB_BYTES);
    localparam int SP_AW     = $clog2(STACK_DEPTH);
    localparam logic [8:0] SW9 = 9'(SCREEN_W);
    localparam logic [8:0] SH9 = 9'(SCREEN_H);
    localparam logic [SP_AW-1:0] SP_LAST = SP_AW'(STACK_DEPTH - 1);

    // pixel mask of one framebuffer column, clipped at the right edge
    function automatic logic [7:0] col_mask(input logic [4:0] col);
        int rem;
        rem = SCREEN_W - 8 * int'(col);
        if (rem >= 8)
        begin
            return 8'hFF;
        end
        else if (rem <= 0)
        begin
            return 8'h00;
        end
        return ~(8'hFF >> rem);
    endfunction

    // architectural and working registers
    logic [11:0]      pc_reg, pc_next, i_reg, i_next;
    logic [SP_AW-1:0] sp_reg, sp_next;
    logic [7:0]       vf_reg, vf_next;
    logic [15:0]      op_reg, op_next;
    logic [7:0]       vx_reg, vx_next, vy_reg, vy_next;
    logic [7:0]       rnd_reg, rnd_next;
    logic [11:0]      addr_reg, addr_next;
    logic [7:0]       x0_reg, x0_next, y0_reg, y0_next;
    logic [3:0]       row_reg, row_next;
    logic [7:0]       line_reg, line_next;
    logic             hit_reg, hit_next;
    logic [7:0]       flag_reg, flag_next;
    logic [11:0]      cnt_reg, cnt_next;
    logic [7:0]       rd_reg, rd_next;
    logic [15:0]      opo_reg, opo_next;
    logic             bad_reg, bad_next;

    // memory ports
    logic              pm_we;
    logic [MEM_AW-1:0] pm_waddr, pm_raddr;
    logic [7:0]        pm_wdata, pm_rdata;
    logic              vr_we;
    logic [3:0]        vr_waddr, vr_raddr;
    logic [7:0]        vr_wdata, vr_rdata;
    logic              st_we;
    logic [SP_AW-1:0]  st_waddr;
    logic [11:0]       st_wdata, st_rdata;
    logic              fb_we;
    logic [FB_AW-1:0]  fb_waddr, fb_raddr;
    logic [7:0]        fb_wdata, fb_rdata;

    c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_pmem (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );
    c8x_ram #(.WIDTH(8), .DEPTH(VREG_NUM)) u_vreg (
        .clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
        .raddr(vr_raddr), .rdata(vr_rdata)
    );
    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(sp_reg), .rdata(st_rdata)
    );
    c8x_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_fb (
        .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    // opcode fields
    logic [3:0]  grp, xi, yi, nib;
    logic [7:0]  nn;
    logic [11:0] nnn;
    assign grp = op_reg[15:12];
    assign xi  = op_reg[11:8];
    assign yi  = op_reg[7:4];
    assign nib = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];

    // sprite row geometry
    logic [8:0]       py9;
    logic [4:0]       col0, col1;
    logic [15:0]      shl;
    logic [7:0]       m0, m1;
    logic [FB_AW-1:0] pos0, pos1;
    logic             has_b1;
    assign py9    = {1'b0, y0_reg} + {5'b0, row_reg};
    assign col0   = x0_reg[7:3];
    assign col1   = col0 + 5'd1;
    assign shl    = {line_reg, 8'h00} >> x0_reg[2:0];
    assign m0     = shl[15:8] & col_mask(col0);
    assign m1     = shl[7:0] & col_mask(col1);
    assign pos0   = FB_AW'(int'(py9) * ROW_BYTES + int'(col0));
    assign pos1   = pos0 + FB_AW'(1);
    assign has_b1 = (x0_reg[2:0] != 3'd0) && (int'(col1) < ROW_BYTES);

    // status
    logic alu_flag;
    always_comb
    begin
        case (nib)
            ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: alu_flag = 1'b1;
            default:                                       alu_flag = 1'b0;
        endcase
    end
    assign stat.sweep_last = (cnt_reg == 12'hFFF);
    assign stat.cls_last   = (int'(cnt_reg) == FB_BYTES - 1);
    assign stat.is_cls     = (op_reg == OP_CLS);
    assign stat.is_drw     = (grp == GRP_DRW);
    assign stat.flag_op    = (grp == GRP_ALU) && alu_flag;
    assign stat.mod_done   = ({1'b0, x0_reg} < SW9) && ({1'b0, y0_reg} < SH9);
    assign stat.row_end    = (row_reg == nib) || (py9 >= SH9);
    assign stat.has_b1     = has_b1;

    // instruction execution
    logic [8:0]  sum9;
    logic        v_we;
    logic [7:0]  v_res;
    logic        bad;
    always_comb
    begin
        sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};
        v_we     = 1'b0;
        v_res    = vy_reg;
        bad      = 1'b0;
        flag_next = flag_reg;
        case (grp)
            GRP_LDI:
            begin
                v_we  = 1'b1;
                v_res = nn;
            end
            GRP_ADDI:
            begin
                v_we  = 1'b1;
                v_res = vx_reg + nn;
            end
            GRP_RND:
            begin
                v_we  = 1'b1;
                v_res = rnd_reg & nn;
            end
            GRP_ALU:
            begin
                v_we = 1'b1;
                case (nib)
                    ALU_MOV: v_res = vy_reg;
                    ALU_OR:  v_res = vx_reg | vy_reg;
                    ALU_AND: v_res = vx_reg & vy_reg;
                    ALU_XOR: v_res = vx_reg ^ vy_reg;
                    ALU_ADD:
                    begin
                        v_res     = sum9[7:0];
                        flag_next = {7'b0, sum9[8]};
                    end
                    ALU_SUB:
                    begin
                        v_res     = vx_reg - vy_reg;
                        flag_next = {7'b0, vx_reg > vy_reg};
                    end
                    ALU_SHR:
                    begin
                        v_res     = vx_reg >> 1;
                        flag_next = {7'b0, vx_reg[0]};
                    end
                    ALU_SUBN:
                    begin
                        v_res     = vy_reg - vx_reg;
                        flag_next = {7'b0, vy_reg > vx_reg};
                    end
                    ALU_SHL:
                    begin
                        v_res     = vx_reg << 1;
                        flag_next = {7'b0, vx_reg[7]};
                    end
                    default:
                    begin
                        v_we = 1'b0;
                        bad  = 1'b1;
                    end
                endcase
            end
            GRP_SYS, GRP_JP, GRP_CALL, GRP_SEI, GRP_SNEI, GRP_SER,
            GRP_SNER, GRP_LDX, GRP_JPV, GRP_DRW: bad = 1'b0;
            default: bad = 1'b1;
        endcase
        if (!cmd.exec)
        begin
            flag_next = flag_reg;
        end
    end

    // register updates
    always_comb
    begin
        pc_next   = pc_reg;
        i_next    = i_reg;
        sp_next   = sp_reg;
        vf_next   = vf_reg;
        op_next   = op_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        rnd_next  = rnd_reg;
        addr_next = addr_reg;
        x0_next   = x0_reg;
        y0_next   = y0_reg;
        row_next  = row_reg;
        line_next = line_reg;
        hit_next  = hit_reg;
        cnt_next  = cnt_reg;
        rd_next   = rd_reg;
        opo_next  = opo_reg;
        bad_next  = bad_reg;

        if (cmd.clr || cmd.cls_step)
        begin
            cnt_next = cnt_reg + 12'd1;
        end
        if (cmd.accept)
        begin
            rnd_next  = rand_byte;
            addr_next = addr;
            rd_next   = '0;
            opo_next  = '0;
            bad_next  = 1'b0;
        end
        if (cmd.fb_cap && (int'(addr_reg) < FB_BYTES))
        begin
            rd_next = fb_rdata;
        end
        if (cmd.fetch_hi)
        begin
            op_next[15:8] = pm_rdata;
        end
        if (cmd.fetch_lo)
        begin
            op_next[7:0] = pm_rdata;
            pc_next      = pc_reg + 12'd2;
        end
        if (cmd.rd_x)
        begin
            vx_next  = vr_rdata;
            opo_next = op_reg;
        end
        if (cmd.rd_y)
        begin
            vy_next = vr_rdata;
        end
        if (cmd.exec)
        begin
            bad_next = bad;
            x0_next  = vx_reg;
            y0_next  = vy_reg;
            row_next = '0;
            hit_next = 1'b0;
            cnt_next = '0;
            case (grp)
                GRP_SYS:
                begin
                    if (op_reg == OP_RET)
                    begin
                        pc_next = st_rdata;
                        sp_next = (sp_reg == '0) ? SP_LAST : sp_reg - SP_AW'(1);
                    end
                end
                GRP_JP:   pc_next = nnn;
                GRP_CALL:
                begin
                    pc_next = nnn;
                    sp_next = (sp_reg == SP_LAST) ? '0 : sp_reg + SP_AW'(1);
                end
                GRP_SEI:  if (vx_reg == nn) pc_next = pc_reg + 12'd2;
                GRP_SNEI: if (vx_reg != nn) pc_next = pc_reg + 12'd2;
                GRP_SER:  if (vx_reg == vy_reg) pc_next = pc_reg + 12'd2;
                GRP_SNER: if (vx_reg != vy_reg) pc_next = pc_reg + 12'd2;
                GRP_LDX:  i_next = nnn;
                GRP_JPV:  pc_next = nnn + {4'b0, vx_reg};
                default:  pc_next = pc_reg;
            endcase
        end
        if (cmd.mod_step)
        begin
            if ({1'b0, x0_reg} >= SW9)
            begin
                x0_next = x0_reg - SW9[7:0];
            end
            if ({1'b0, y0_reg} >= SH9)
            begin
                y0_next = y0_reg - SH9[7:0];
            end
        end
        if (cmd.row_b0)
        begin
            line_next = pm_rdata;
        end
        if (cmd.row_w0)
        begin
            if ((fb_rdata & m0) != 8'h00)
            begin
                hit_next = 1'b1;
            end
            if (!has_b1)
            begin
                row_next = row_reg + 4'd1;
            end
        end
        if (cmd.row_w1)
        begin
            if ((fb_rdata & m1) != 8'h00)
            begin
                hit_next = 1'b1;
            end
            row_next = row_reg + 4'd1;
        end
        // shadow copy of VF for the result port
        if (vr_we && (vr_waddr == VF_IDX) && !cmd.clr)
        begin
            vf_next = vr_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_START;
            i_reg   <= '0;
            sp_reg  <= '0;
            vf_reg  <= '0;
            cnt_reg <= '0;
            rd_reg  <= '0;
            opo_reg <= '0;
            bad_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            i_reg   <= i_next;
            sp_reg  <= sp_next;
            vf_reg  <= vf_next;
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            opo_reg <= opo_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        rnd_reg  <= rnd_next;
        addr_reg <= addr_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        row_reg  <= row_next;
        line_reg <= line_next;
        hit_reg  <= hit_next;
        flag_reg <= flag_next;
    end

    // program memory port
    always_comb
    begin
        pm_we    = cmd.clr || cmd.load_wr;
        pm_waddr = cmd.clr ? cnt_reg : addr;
        pm_wdata = cmd.clr ? 8'h00 : data;
        if (cmd.row_mem)
        begin
            pm_raddr = i_reg + {8'b0, row_reg};
        end
        else if (cmd.fetch_hi)
        begin
            pm_raddr = pc_reg + 12'd1;
        end
        else
        begin
            pm_raddr = pc_reg;
        end
    end

    // variable register port
    always_comb
    begin
        vr_raddr = cmd.rd_x ? yi : ((grp == GRP_JPV) ? 4'd0 : xi);
        if (cmd.clr)
        begin
            vr_we    = (cnt_reg < 12'(VREG_NUM));
            vr_waddr = cnt_reg[VREG_AW-1:0];
            vr_wdata = 8'h00;
        end
        else if (cmd.wr_flag)
        begin
            vr_we    = 1'b1;
            vr_waddr = VF_IDX;
            vr_wdata = stat.is_drw ? {7'b0, hit_reg} : flag_reg;
        end
        else
        begin
            vr_we    = cmd.exec && v_we;
            vr_waddr = xi;
            vr_wdata = v_res;
        end
    end

    // call stack port
    always_comb
    begin
        if (cmd.clr)
        begin
            st_we    = (int'(cnt_reg) < STACK_DEPTH);
            st_waddr = cnt_reg[SP_AW-1:0];
            st_wdata = '0;
        end
        else
        begin
            st_we    = cmd.exec && (grp == GRP_CALL);
            st_waddr = (sp_reg == SP_LAST) ? '0 : sp_reg + SP_AW'(1);
            st_wdata = pc_reg;
        end
    end

    // framebuffer port
    always_comb
    begin
        fb_raddr = addr[FB_AW-1:0];
        if (cmd.row_b0)
        begin
            fb_raddr = pos0;
        end
        else if (cmd.row_w0)
        begin
            fb_raddr = pos1;
        end
        fb_we    = 1'b0;
        fb_waddr = cnt_reg[FB_AW-1:0];
        fb_wdata = 8'h00;
        if (cmd.clr || cmd.cls_step)
        begin
            fb_we = (int'(cnt_reg) < FB_BYTES);
        end
        else if (cmd.row_w0)
        begin
            fb_we    = 1'b1;
            fb_waddr = pos0;
            fb_wdata = fb_rdata ^ m0;
        end
        else if (cmd.row_w1)
        begin
            fb_we    = 1'b1;
            fb_waddr = pos1;
            fb_wdata = fb_rdata ^ m1;
        end
    end

    assign prog_counter    = pc_reg;
    assign index_value     = i_reg;
    assign flag_value      = vf_reg;
    assign read_byte       = rd_reg;
    assign executed_opcode = opo_reg;
    assign unimplemented   = bad_reg;

endmodule

// File: rtl/core/c8x_checker.sv
module c8x_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  read_byte,
    input logic [15:0] executed_opcode,
    input logic        unimplemented
);

    // an accepted beat keeps the unit busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // no new beat is taken while a result is shown
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");

    // a framebuffer byte and a fetched opcode never come together
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && (read_byte != 8'h00) |-> (executed_opcode == 16'h0000) && !unimplemented)
        else $error("read and execute results mixed");

endmodule

bind chip8_instruction_execute_unit c8x_checker u_c8x_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .read_byte(read_byte), .executed_opcode(executed_opcode),
    .unimplemented(unimplemented)
);

// File: tb/sv/tb_top.sv
module tb_top;
    import c8x_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_IDLE  = 2'd3;
    localparam logic [3:0] GRP_KEY    = 4'hE;
    localparam logic [3:0] GRP_MISC   = 4'hF;
    localparam logic [3:0] ALU_BAD    = 4'h8;
    localparam int         ROW_BYTES  = 8;
    localparam int         FB_BYTES   = 256;
    localparam int         CYCLE_CAP  = 2500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  mode = '0;
    logic [11:0] addr = '0;
    logic [7:0]  data = '0;
    logic [7:0]  rand_byte = '0;
    logic        busy;
    logic        done;
    logic [11:0] prog_counter;
    logic [11:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  read_byte;
    logic [15:0] executed_opcode;
    logic        unimplemented;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] idx;
        logic [7:0]  vf;
        logic [7:0]  rb;
        logic [15:0] op;
        logic        bad;
    } cpu_view_t;

    // shadow machine state
    logic [7:0]  mem_shadow [MEM_BYTES];
    logic [7:0]  vreg [VREG_NUM];
    logic [11:0] stack_shadow [16];
    logic [3:0]  sp_shadow;
    logic [11:0] pc_shadow;
    logic [11:0] idx_shadow;
    logic [7:0]  fb_shadow [FB_BYTES];

    cpu_view_t   pending_views [$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;

    chip8_instruction_execute_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .addr(addr), .data(data), .rand_byte(rand_byte),
        .done(done), .prog_counter(prog_counter), .index_value(index_value),
        .flag_value(flag_value), .read_byte(read_byte),
        .executed_opcode(executed_opcode), .unimplemented(unimplemented)
    );

    always #10 clk = ~clk;

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // XOR a sprite into the shadow screen, return collision
    function automatic logic [7:0] draw_rows(input logic [7:0] vx, input logic [7:0] vy,
                                            input logic [3:0] rows);
        int x0, y0, px, py, pos;
        logic [7:0] line, mask;
        logic hit;
        x0 = vx % 64;
        y0 = vy % 32;
        hit = 1'b0;
        for (int r = 0; r < rows; r++)
        begin
            py = y0 + r;
            if (py >= 32)
                break;
            line = mem_shadow[12'(idx_shadow + r)];
            for (int c = 0; c < 8; c++)
            begin
                px = x0 + c;
                if (px >= 64)
                    break;
                if (line[7-c])
                begin
                    pos = py * ROW_BYTES + px / 8;
                    mask = 8'h80 >> (px % 8);
                    if ((fb_shadow[pos] & mask) != 0)
                        hit = 1'b1;
                    fb_shadow[pos] = fb_shadow[pos] ^ mask;
                end
            end
        end
        return {7'd0, hit};
    endfunction

    // execute one opcode on the shadow state; returns 1 if implemented
    function automatic bit exec_shadow(input logic [15:0] op, input logic [7:0] rnd);
        logic [3:0] x, y, n;
        logic [7:0] nn, a, b;
        logic [11:0] nnn;
        logic [8:0] wide;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        a = vreg[x];
        b = vreg[y];
        case (op[15:12])
            GRP_SYS:
                if (op == OP_CLS)
                    for (int i = 0; i < FB_BYTES; i++)
                        fb_shadow[i] = '0;
                else if (op == OP_RET)
                begin
                    pc_shadow = stack_shadow[sp_shadow];
                    sp_shadow = sp_shadow - 1'b1;
                end
            GRP_JP:   pc_shadow = nnn;
            GRP_CALL:
            begin
                sp_shadow = sp_shadow + 1'b1;
                stack_shadow[sp_shadow] = pc_shadow;
                pc_shadow = nnn;
            end
            GRP_SEI:  if (a == nn) pc_shadow = pc_shadow + 12'd2;
            GRP_SNEI: if (a != nn) pc_shadow = pc_shadow + 12'd2;
            GRP_SER:  if (a == b) pc_shadow = pc_shadow + 12'd2;
            GRP_LDI:  vreg[x] = nn;
            GRP_ADDI: vreg[x] = a + nn;
            GRP_ALU:
                case (n)
                    ALU_MOV: vreg[x] = b;
                    ALU_OR:  vreg[x] = a | b;
                    ALU_AND: vreg[x] = a & b;
                    ALU_XOR: vreg[x] = a ^ b;
                    ALU_ADD:
                    begin
                        wide = a + b;
                        vreg[x] = wide[7:0];
                        vreg[VF_IDX] = {7'd0, wide[8]};
                    end
                    ALU_SUB:
                    begin
                        vreg[x] = a - b;
                        vreg[VF_IDX] = {7'd0, a > b};
                    end
                    ALU_SHR:
                    begin
                        vreg[x] = a >> 1;
                        vreg[VF_IDX] = {7'd0, a[0]};
                    end
                    ALU_SUBN:
                    begin
                        vreg[x] = b - a;
                        vreg[VF_IDX] = {7'd0, b > a};
                    end
                    ALU_SHL:
                    begin
                        vreg[x] = a << 1;
                        vreg[VF_IDX] = {7'd0, a[7]};
                    end
                    default: return 0;
                endcase
            GRP_SNER: if (a != b) pc_shadow = pc_shadow + 12'd2;
            GRP_LDX:  idx_shadow = nnn;
            GRP_JPV:  pc_shadow = nnn + {4'd0, vreg[0]};
            GRP_RND:  vreg[x] = rnd & nn;
            GRP_DRW:  vreg[VF_IDX] = draw_rows(a, b, n);
            default:  return 0;
        endcase
        return 1;
    endfunction

    // apply an accepted beat to the shadow and queue the expected view
    task automatic predict_beat(input logic [1:0] m, input logic [11:0] a,
                                input logic [7:0] d, input logic [7:0] r);
        cpu_view_t v;
        v = '0;
        if (m == MODE_LOAD)
            mem_shadow[a] = d;
        else if (m == MODE_EXEC)
        begin
            v.op = {mem_shadow[pc_shadow], mem_shadow[12'(pc_shadow + 1)]};
            pc_shadow = pc_shadow + 12'd2;
            v.bad = !exec_shadow(v.op, r);
        end
        else if (m == MODE_READ && a < FB_BYTES)
            v.rb = fb_shadow[a];
        v.pc = pc_shadow;
        v.idx = idx_shadow;
        v.vf = vreg[VF_IDX];
        pending_views.push_back(v);
    endtask

    // send one beat; start stays high unless an idle gap follows
    task automatic send_beat(input logic [1:0] m, input logic [11:0] a,
                             input logic [7:0] d, input logic [7:0] r);
        int gap;
        mode <= m;
        addr <= a;
        data <= d;
        rand_byte <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beat(m, a, d, r);
        gap = (!no_idle && $urandom_range(0, 99) < 32) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // place an opcode at the current pc and run it
    task automatic run_opcode(input logic [15:0] op, input logic [7:0] rnd = 8'h00);
        send_beat(MODE_LOAD, pc_shadow, op[15:8], $urandom_range(0, 255));
        send_beat(MODE_LOAD, 12'(pc_shadow + 1), op[7:0], $urandom_range(0, 255));
        send_beat(MODE_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255), rnd);
    endtask

    // hold off until every expected view has arrived
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        cpu_view_t w;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: unexpected result beat", $realtime);
                errors++;
            end
            else
            begin
                w = pending_views.pop_front();
                if (prog_counter !== w.pc)
                begin
                    $display("%0t: pc exp %h got %h", $realtime, w.pc, prog_counter);
                    errors++;
                end
                if (index_value !== w.idx)
                begin
                    $display("%0t: I exp %h got %h", $realtime, w.idx, index_value);
                    errors++;
                end
                if (flag_value !== w.vf)
                begin
                    $display("%0t: VF exp %h got %h", $realtime, w.vf, flag_value);
                    errors++;
                end
                if (read_byte !== w.rb)
                begin
                    $display("%0t: fb byte exp %h got %h", $realtime, w.rb, read_byte);
                    errors++;
                end
                if (executed_opcode !== w.op)
                begin
                    $display("%0t: opcode exp %h got %h", $realtime, w.op, executed_opcode);
                    errors++;
                end
                if (unimplemented !== w.bad)
                begin
                    $display("%0t: unimpl exp %b got %b", $realtime, w.bad, unimplemented);
                    errors++;
                end
            end
        end
    end

    // loads, reads (in and out of range) and mode three
    task automatic test_load_read();
        send_beat(MODE_LOAD, 12'hFFF, 8'hFF, 8'hFF);
        send_beat(MODE_LOAD, 12'h000, 8'h00, 8'h00);
        send_beat(MODE_READ, 12'd0, 8'h00, 8'h00);
        send_beat(MODE_READ, 12'd255, 8'hFF, 8'hFF);
        send_beat(MODE_READ, 12'd256, 8'h00, 8'h00);
        send_beat(MODE_READ, 12'hFFF, 8'hFF, 8'hFF);
        send_beat(MODE_IDLE, 12'hABC, 8'h5A, 8'hA5);
    endtask

    // 8XYn group with flag edge cases, VF as destination
    task automatic test_alu();
        run_opcode({GRP_LDI, 4'h1, 8'hFF});
        run_opcode({GRP_LDI, 4'h2, 8'h01});
        run_opcode({GRP_ALU, 4'h1, 4'h2, ALU_ADD});
        run_opcode({GRP_ALU, 4'h2, 4'h1, ALU_SUB});
        run_opcode({GRP_ALU, 4'h1, 4'h1, ALU_SUB});
        run_opcode({GRP_ALU, 4'h2, 4'h1, ALU_SUBN});
        run_opcode({GRP_LDI, 4'h3, 8'h81});
        run_opcode({GRP_ALU, 4'h3, 4'h0, ALU_SHR});
        run_opcode({GRP_LDI, 4'h3, 8'h81});
        run_opcode({GRP_ALU, 4'h3, 4'h0, ALU_SHL});
        run_opcode({GRP_ALU, 4'h4, 4'h3, ALU_OR});
        run_opcode({GRP_ALU, 4'h4, 4'h2, ALU_AND});
        run_opcode({GRP_ALU, 4'h4, 4'h3, ALU_XOR});
        run_opcode({GRP_ALU, 4'h5, 4'h3, ALU_MOV});
        run_opcode({GRP_LDI, 4'hF, 8'hF0});
        run_opcode({GRP_ALU, 4'hF, 4'h3, ALU_ADD});
        run_opcode({GRP_ADDI, 4'h1, 8'hFF});
        run_opcode({GRP_ALU, 4'h1, 4'h2, ALU_BAD});
        run_opcode({GRP_RND, 4'h6, 8'h3C}, 8'hFF);
    endtask

    // jumps, calls, skips, stack and address wrap, unknown groups
    task automatic test_flow();
        run_opcode({GRP_SEI, 4'h6, 8'h3C});
        run_opcode({GRP_SNEI, 4'h6, 8'h3C});
        run_opcode({GRP_SER, 4'h6, 4'h6, 4'hF});
        run_opcode({GRP_SNER, 4'h6, 4'h1, 4'h7});
        run_opcode(16'h0123);
        run_opcode({GRP_CALL, 12'h300});
        run_opcode(OP_RET);
        run_opcode(OP_RET);
        run_opcode({GRP_JP, 12'hFFF});
        run_opcode({GRP_LDI, 4'h0, 8'hFF});
        run_opcode({GRP_JPV, 12'hFFF});
        run_opcode({GRP_KEY, 12'h09E});
        run_opcode({GRP_MISC, 12'h165});
        for (int i = 0; i < 18; i++)
            run_opcode({GRP_CALL, 12'($urandom_range(0, 4095))});
        for (int i = 0; i < 18; i++)
            run_opcode(OP_RET);
    endtask

    // sprites: clipping right and bottom, collision, I wrap, clear
    task automatic test_draw();
        run_opcode({GRP_LDX, 12'hFFE});
        run_opcode({GRP_LDI, 4'h7, 8'd60});
        run_opcode({GRP_LDI, 4'h8, 8'd30});
        run_opcode({GRP_DRW, 4'h7, 4'h8, 4'hF});
        run_opcode({GRP_DRW, 4'h7, 4'h8, 4'hF});
        run_opcode({GRP_LDI, 4'h7, 8'hFF});
        run_opcode({GRP_DRW, 4'h7, 4'h7, 4'h0});
        run_opcode({GRP_DRW, 4'h7, 4'h7, 4'h4});
        for (int i = 0; i < 8; i++)
            send_beat(MODE_READ, 12'($urandom_range(0, 255)), 8'h00, 8'h00);
        run_opcode(OP_CLS);
        send_beat(MODE_READ, 12'd255, 8'h00, 8'h00);
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [3:0] g, x, y;
        logic [7:0] nn;
        g = 4'($urandom_range(0, 15));
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        nn = 8'($urandom_range(0, 255));
        if ((g == GRP_SEI || g == GRP_SNEI) && $urandom_range(0, 1))
            nn = vreg[x];
        if (g == GRP_SYS)
        begin
            if ($urandom_range(0, 39) == 0)
                return OP_CLS;
            return $urandom_range(0, 2) ? OP_RET : {g, x, y, nn[3:0]};
        end
        if (g == GRP_ALU && $urandom_range(0, 7) != 0)
            nn[3:0] = $urandom_range(0, 8) == 8 ? ALU_SHL : 4'($urandom_range(0, 7));
        return {g, x, nn};
    endfunction

    // random programs with loads, reads and idle noise mixed in
    task automatic test_random(input int beats);
        int k, sel;
        k = 0;
        while (k < beats)
        begin
            no_idle = (k > beats / 3 && k < beats / 3 + 200);
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                run_opcode(pick_opcode(), $urandom_range(0, 255));
                k += 3;
            end
            else if (sel < 78)
                send_beat(MODE_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            else if (sel < 86)
                send_beat(MODE_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            else if (sel < 96)
                send_beat(MODE_READ, $urandom_range(0, 9) ? $urandom_range(0, 255)
                          : $urandom_range(0, 4095), $urandom_range(0, 255), 8'h00);
            else
                send_beat(MODE_IDLE, $urandom_range(0, 4095), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            if (sel >= 70)
                k++;
            if (k % 500 < 3 && sel < 70)
                drain_results();
        end
        no_idle = 0;
    endtask

    initial
    begin
        for (int i = 0; i < MEM_BYTES; i++)
            mem_shadow[i] = '0;
        for (int i = 0; i < 16; i++)
        begin
            vreg[i] = '0;
            stack_shadow[i] = '0;
        end
        for (int i = 0; i < FB_BYTES; i++)
            fb_shadow[i] = '0;
        sp_shadow = '0;
        pc_shadow = PC_START;
        idx_shadow = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_read();
        test_alu();
        drain_results();
        test_flow();
        test_draw();
        drain_results();
        test_random(1800);
        drain_results();
        repeat (300) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
